// ===== sv/fsip_pkg.sv =====
// ----------------------------------------------------------------------------
// fsip_pkg: shared types and constants of the format string integer printer
// Holds the character codes, digit geometry, controller states and the
// digit-to-ASCII mapping used by the converter and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsip_pkg;

	localparam int ARG_W      = 32;
	localparam int DIGIT_W    = 4;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
	localparam int CHAR_W     = 8;
	localparam int CCOUNT_W   = 16;

	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
	localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A_BASE  = 8'h57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} fsip_state_t;

	// Lowercase hex digit for a nibble; decimal digits fall in the 0-9 range.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] nib);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
		if (nib < 4'd10) begin
			digit_char = CH_ZERO + ext;
		end else begin
			digit_char = CH_A_BASE + ext;
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/fsip_b2d.sv =====
// ----------------------------------------------------------------------------
// fsip_b2d: bit-serial binary to BCD converter
// Shift-and-add-3 conversion that takes one argument bit per cycle, most
// significant first, and pulses done when all ten decimal digits are ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsip_b2d
	import fsip_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [ARG_W-1:0] value,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	localparam int CNT_W = $clog2(ARG_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ARG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ARG_W-1:0] val_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// Every digit of five or more gets three added before the next shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[ARG_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], val_q[ARG_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

// ===== sv/format_string_integer_printer.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_printer: printf-style integer printer
// Takes one format byte per beat and emits zero to eleven characters.
// ----------------------------------------------------------------------------
// One input beat is taken at a time; in_ready is high only while no earlier
// item is still being printed. An ordinary byte is held in ST_CHAR and then
// leaves as one character through the output register. A '%' byte is absorbed
// without printing. A '%x' conversion walks ten nibble slots, one per cycle
// unless a digit waits on the output, skipping leading zeros and emitting the
// rest. A '%d' conversion first runs the bit-serial BCD converter, one
// argument bit per cycle, then an optional '-' and the ten digit slots, which
// may also wait on the output. The character count saturates at
// 2^COUNT_WIDTH-1 and char_count shows its low 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module format_string_integer_printer
	import fsip_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                start_req,
	input  wire logic [CHAR_W-1:0]   fmt_char,
	input  wire logic [ARG_W-1:0]    arg_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [CHAR_W-1:0]        out_char,
	output logic [CCOUNT_W-1:0]      char_count,
	output logic                     last
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam int LEFT_W = $clog2(BCD_DIGITS + 1);
	localparam logic [LEFT_W-1:0] LEFT_FULL = LEFT_W'(BCD_DIGITS);
	localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

	fsip_state_t state_q, state_d;

	logic                   pending_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   neg_q;
	logic [BCD_W-1:0]       digits_q;
	logic [LEFT_W-1:0]      left_q;
	logic                   seen_q;

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic [CCOUNT_W-1:0]    out_count_q;
	logic                   out_last_q;

	logic                   in_fire;
	logic                   pend_eff;
	logic                   is_d;
	logic                   is_x;
	logic                   can_load;
	logic [DIGIT_W-1:0]     top_nib;
	logic                   skip_zero;
	logic [ARG_W-1:0]       mag;

	logic                   emit_en;
	logic [CHAR_W-1:0]      emit_char;
	logic                   emit_last;
	logic                   shift_en;
	logic                   conv_start;
	logic                   conv_done;
	logic [BCD_W-1:0]       conv_bcd;

	logic [COUNT_WIDTH-1:0]          total_next;
	logic [COUNT_WIDTH+CCOUNT_W-1:0] total_ext;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign pend_eff  = pending_q && !start_req;
	assign is_d      = (fmt_char == CH_D);
	assign is_x      = (fmt_char == CH_X);
	assign can_load  = !out_valid_q || out_ready;
	assign top_nib   = digits_q[BCD_W-1 -: DIGIT_W];
	// Leading zeros are dropped, but the final slot always prints.
	assign skip_zero = (top_nib == '0) && !seen_q && (left_q != LEFT_ONE);
	assign mag       = arg_value[ARG_W-1] ? (ARG_W'(0) - arg_value) : arg_value;

	fsip_b2d u_b2d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (pend_eff) begin
						if (is_d) begin
							state_d = ST_CONV;
						end else if (is_x) begin
							state_d = ST_EMIT;
						end
					end else if (fmt_char != CH_PERCENT) begin
						state_d = ST_CHAR;
					end
				end
			end
			ST_CHAR: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (can_load) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!skip_zero && can_load && (left_q == LEFT_ONE)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit_en    = 1'b0;
		emit_char  = char_q;
		emit_last  = 1'b0;
		shift_en   = 1'b0;
		conv_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				conv_start = in_fire && pend_eff && is_d;
			end
			ST_CHAR: begin
				emit_en   = can_load;
				emit_last = 1'b1;
			end
			ST_CONV: begin
			end
			ST_SIGN: begin
				emit_en   = can_load;
				emit_char = CH_MINUS;
			end
			ST_EMIT: begin
				emit_char = digit_char(top_nib);
				emit_last = (left_q == LEFT_ONE);
				if (skip_zero) begin
					shift_en = 1'b1;
				end else begin
					emit_en  = can_load;
					shift_en = can_load;
				end
			end
			default: begin
			end
		endcase
	end

	assign total_next = (total_q == CNT_MAX) ? total_q : (total_q + 1'b1);
	assign total_ext  = {{CCOUNT_W{1'b0}}, total_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			seen_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				pending_q <= pend_eff ? 1'b0 : (fmt_char == CH_PERCENT);
				if (start_req) begin
					total_q <= '0;
				end
			end else if (emit_en) begin
				total_q <= total_next;
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((in_fire && pend_eff && is_x) || conv_done) begin
				left_q <= LEFT_FULL;
				seen_q <= 1'b0;
			end else if (shift_en) begin
				left_q <= left_q - 1'b1;
				if (top_nib != '0) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_q <= fmt_char;
			neg_q  <= arg_value[ARG_W-1];
		end
		if (in_fire && pend_eff && is_x) begin
			digits_q <= {{(BCD_W-ARG_W){1'b0}}, arg_value};
		end else if (conv_done) begin
			digits_q <= conv_bcd;
		end else if (shift_en) begin
			digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
		if (emit_en) begin
			out_char_q  <= emit_char;
			out_last_q  <= emit_last;
			out_count_q <= total_ext[CCOUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign char_count = out_count_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

// ===== sim/format_string_integer_printer_tb.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_printer_tb: self-checking bench for the integer printer
// Feeds format bytes with their argument through a valid/ready driver, keeps
// its own model of the pending-percent flag and the saturating character count,
// and compares every printed character beat against the predicted text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module format_string_integer_printer_tb;
	import fsip_pkg::*;

	localparam int CNT_W       = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [CHAR_W-1:0] CH_S = "s";
	localparam logic [0:15][7:0] DIGIT_SYMS = "0123456789abcdef";

	typedef struct {
		logic              start;
		logic [CHAR_W-1:0] ch;
		logic [ARG_W-1:0]  arg;
		int                phase;
	} format_byte_t;

	typedef struct {
		logic [CHAR_W-1:0]   ch;
		logic [CCOUNT_W-1:0] cnt;
		logic                fin;
	} printed_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_req = 1'b0;
	logic [CHAR_W-1:0] fmt_char = '0;
	logic [ARG_W-1:0] arg_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic [CCOUNT_W-1:0] char_count;
	logic last;

	format_byte_t  format_q[$];
	printed_char_t printed_q[$];
	format_byte_t  next_byte;
	printed_char_t want;

	// Shadow of the block's state, advanced once per accepted input beat.
	logic             pct_armed = 1'b0;
	logic [CNT_W-1:0] printed_total = '0;

	int cur_phase = 1;
	int sent_cnt = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int n_in = 0;
	int n_out = 0;
	int err_cnt = 0;
	int quiet_cycles = 0;
	logic any_beat;

	format_string_integer_printer #(
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.fmt_char   (fmt_char),
		.arg_value  (arg_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.char_count (char_count),
		.last       (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int sender_idle_pct(int ph);
		case (ph)
			1: return 6;
			2: return 71;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct(int ph);
		case (ph)
			1: return 71;
			2: return 6;
			default: return 0;
		endcase
	endfunction

	// Works out the characters one format byte prints and queues them.
	function automatic void render_format_byte(input logic st, input logic [CHAR_W-1:0] c,
			input logic [ARG_W-1:0] a);
		logic [CHAR_W-1:0] text [0:11];
		logic [CHAR_W-1:0] rev [0:11];
		logic [ARG_W-1:0] mag;
		logic [ARG_W-1:0] radix;
		int n;
		int nd;
		n = 0;
		if (st) begin
			pct_armed = 1'b0;
			printed_total = '0;
		end
		if (pct_armed) begin
			pct_armed = 1'b0;
			if (c == CH_D || c == CH_X) begin
				radix = (c == CH_D) ? 32'd10 : 32'd16;
				mag = a;
				// Negating the most negative value wraps to its own unsigned magnitude.
				if (c == CH_D && a[ARG_W-1]) begin
					mag = -a;
					text[n] = CH_MINUS;
					n++;
				end
				nd = 0;
				do begin
					rev[nd] = DIGIT_SYMS[4'(mag % radix)];
					mag = mag / radix;
					nd++;
				end while (mag != 0);
				for (int i = nd - 1; i >= 0; i--) begin
					text[n] = rev[i];
					n++;
				end
			end
		end else if (c == CH_PERCENT) begin
			pct_armed = 1'b1;
		end else begin
			text[n] = c;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			if (printed_total != '1) begin
				printed_total++;
			end
			printed_q.push_back('{text[i], CCOUNT_W'(printed_total), (i == n - 1)});
		end
	endfunction

	function automatic void add_byte(logic st, logic [CHAR_W-1:0] c, logic [ARG_W-1:0] a,
			int ph);
		format_q.push_back('{st, c, a, ph});
	endfunction

	function automatic void add_conv(logic st, logic [CHAR_W-1:0] c, logic [ARG_W-1:0] a,
			int ph);
		add_byte(st, CH_PERCENT, $urandom, ph);
		add_byte(1'b0, c, a, ph);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_plain();
		logic [CHAR_W-1:0] c;
		do begin
			if ($urandom_range(3) == 0) begin
				c = 8'($urandom_range(255));
			end else begin
				c = 8'($urandom_range(126, 32));
			end
		end while (c == CH_PERCENT);
		return c;
	endfunction

	// Arguments lean toward short numbers, sign changes and digit-count boundaries.
	function automatic logic [ARG_W-1:0] pick_arg();
		case ($urandom_range(6))
			0: return $urandom;
			1: return 32'($urandom_range(9));
			2: return 32'($urandom_range(99999));
			3: return -32'($urandom_range(99999, 1));
			4: return $urandom >> $urandom_range(31);
			5: return -($urandom >> $urandom_range(31));
			default: begin
				case ($urandom_range(5))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'd999_999_999;
					3: return 32'd1_000_000_000;
					4: return 32'h1000_0000;
					default: return 32'h0fff_ffff;
				endcase
			end
		endcase
	endfunction

	// Mostly well-formed strings; a tenth of the tokens leave a '%' dangling
	// ahead of a fresh start.
	function automatic void add_random_strings(int amount, int ph);
		int goal;
		int ntok;
		int r;
		logic st;
		goal = format_q.size() + amount;
		while (format_q.size() < goal) begin
			ntok = $urandom_range(8, 2);
			st = 1'b1;
			for (int t = 0; t < ntok; t++) begin
				r = $urandom_range(99);
				if (r < 35) begin
					add_byte(st, pick_plain(), $urandom, ph);
				end else if (r < 60) begin
					add_conv(st, CH_D, pick_arg(), ph);
				end else if (r < 80) begin
					add_conv(st, CH_X, pick_arg(), ph);
				end else if (r < 90) begin
					add_conv(st, 8'($urandom_range(255)), pick_arg(), ph);
				end else begin
					add_byte(st, CH_PERCENT, $urandom, ph);
					add_byte(1'b1, pick_plain(), $urandom, ph);
				end
				st = 1'b0;
			end
		end
	endfunction

	// Sender: offers the next format byte unless it decides to idle this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			start_req <= 1'b0;
			fmt_char <= '0;
			arg_value <= '0;
		end else if (!in_valid || in_ready) begin
			if (format_q.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct(format_q[0].phase)) begin
				next_byte = format_q.pop_front();
				in_valid <= 1'b1;
				start_req <= next_byte.start;
				fmt_char <= next_byte.ch;
				arg_value <= next_byte.arg;
				cur_phase <= next_byte.phase;
				sent_cnt <= sent_cnt + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off early on so the block backs up, then random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_cnt >= 12) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct(cur_phase));
		end
	end

	// Monitor: predicts on every input beat, checks every output beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			any_beat = 1'b0;
			if (in_valid && in_ready) begin
				render_format_byte(start_req, fmt_char, arg_value);
				n_in++;
				any_beat = 1'b1;
			end
			if (out_valid && out_ready) begin
				n_out++;
				any_beat = 1'b1;
				if (printed_q.size() == 0) begin
					$error("unexpected character beat: out_char 0x%02h", out_char);
					err_cnt++;
				end else begin
					want = printed_q.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
						err_cnt++;
					end
					if (char_count !== want.cnt) begin
						$error("char_count: expected %0d, got %0d", want.cnt, char_count);
						err_cnt++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0b, got %0b", want.fin, last);
						err_cnt++;
					end
				end
			end
			if (any_beat) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d characters still expected",
					STALL_LIMIT, printed_q.size());
				$display("format_string_integer_printer_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// Directed opening: extremes of both conversions and the odd cases.
		add_byte(1'b1, "H", $urandom, 1);
		add_conv(1'b0, CH_D, 32'h0000_0000, 1);
		add_conv(1'b0, CH_D, 32'h8000_0000, 1);
		add_conv(1'b0, CH_D, 32'h7fff_ffff, 1);
		add_conv(1'b0, CH_D, 32'hffff_ffff, 1);
		add_conv(1'b0, CH_X, 32'hffff_ffff, 1);
		add_conv(1'b0, CH_X, 32'h0000_0000, 1);
		add_conv(1'b0, CH_PERCENT, $urandom, 1);
		add_conv(1'b0, CH_S, $urandom, 1);
		add_byte(1'b0, 8'h00, $urandom, 1);
		add_byte(1'b0, 8'hff, $urandom, 1);
		add_conv(1'b0, 8'h00, $urandom, 1);
		// A start on the byte after '%' drops the pending conversion.
		add_byte(1'b0, CH_PERCENT, $urandom, 1);
		add_byte(1'b1, CH_D, $urandom, 1);
		add_conv(1'b1, CH_X, 32'hdead_beef, 1);

		add_random_strings(55, 1);
		add_random_strings(45, 2);
		add_random_strings(35, 3);

		// Short closing string with the most negative value, then a fresh start.
		add_byte(1'b1, "Z", $urandom, 3);
		add_conv(1'b0, CH_D, 32'h8000_0000, 3);
		add_byte(1'b1, "A", $urandom, 3);
		add_byte(1'b0, "B", $urandom, 3);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(negedge clk);
		end while (format_q.size() != 0 || in_valid || printed_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d format bytes and %0d printed characters across three stall mixes,",
			n_in, n_out);
		$display("including a long output hold-off that backed up the input; %0d mismatches.",
			err_cnt);
		if (err_cnt == 0) begin
			$display("format_string_integer_printer_tb OK");
		end else begin
			$display("format_string_integer_printer_tb NOT OK");
		end
		$finish;
	end

endmodule
